/* hdl/dsrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dsrb_pkg;

   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned PAGE_BYTES = 4096;
   localparam int unsigned BYTES_W    = 32 + PAGE_SHIFT;
   localparam int unsigned COUNT_W    = $clog2(BYTES_W);

   localparam int unsigned HD_WIDTH_I  = 1920;
   localparam int unsigned HD_HEIGHT_I = 1080;
   localparam int unsigned FULL_HD_PAGES_I = (HD_WIDTH_I * HD_HEIGHT_I * 4) / PAGE_BYTES;

   localparam logic [31:0] HD_WIDTH      = 32'(HD_WIDTH_I);
   localparam logic [31:0] HD_HEIGHT     = 32'(HD_HEIGHT_I);
   localparam logic [31:0] HD_STRIDE     = 32'(HD_WIDTH_I * 4);
   localparam logic [31:0] FULL_HD_PAGES = 32'(FULL_HD_PAGES_I);
   localparam logic [31:0] DEF_DIM       = 32'd1024;
   localparam logic [31:0] DEF_STRIDE    = 32'd4096;

   localparam logic WIN_RING    = 1'b0;
   localparam logic WIN_SURFACE = 1'b1;
   localparam logic CMD_READ    = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;

   localparam logic [15:0] SURF_STATUS = 16'h0000;
   localparam logic [15:0] SURF_BASE0  = 16'h1000;
   localparam logic [15:0] SURF_PAGES0 = 16'h1008;
   localparam logic [15:0] SURF_BASE1  = 16'h1010;
   localparam logic [15:0] SURF_PAGES1 = 16'h1018;
   localparam logic [15:0] SURF_STRIDE = 16'h1020;

   localparam logic [15:0] CQ_CONTROL = 16'h1000;
   localparam logic [15:0] CQ_LEN0    = 16'h1004;
   localparam logic [15:0] CQ_HEAD    = 16'h1008;
   localparam logic [15:0] CQ_TAIL    = 16'h100c;
   localparam logic [15:0] CQ_LEN1    = 16'h1010;
   localparam logic [15:0] CQ_PAGE0   = 16'h101c;
   localparam logic [15:0] CQ_PAGE1   = 16'h1030;
   localparam logic [15:0] CQ_COMMAND = 16'h1034;

   localparam int unsigned REQ_TDATA_W = 80;
   localparam int unsigned RSP_TDATA_W = 136;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* hdl/dsrb_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsrb_div (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [dsrb_pkg::BYTES_W-1:0]          dividend,
   input  wire  [31:0]                           divisor,
   output logic [31:0]                           quotient,
   output dsrb_pkg::div_status_type              status
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [dsrb_pkg::COUNT_W-1:0]      count_ff;
   logic [dsrb_pkg::BYTES_W-1:0]      quo_ff;
   logic [31:0]                       rem_ff;
   logic [31:0]                       dvs_ff;

   logic [32:0] trial;
   logic [33:0] diff;
   logic        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[dsrb_pkg::BYTES_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      ge    = ~diff[33];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (start && !busy_ff) begin
            busy_ff  <= 1'b1;
            done_ff  <= 1'b0;
            count_ff <= dsrb_pkg::COUNT_W'(dsrb_pkg::BYTES_W - 1);
            quo_ff   <= dividend;
            rem_ff   <= '0;
            dvs_ff   <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[dsrb_pkg::BYTES_W-2:0], ge};
            rem_ff <= ge ? diff[31:0] : trial[31:0];
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff  <= 1'b0;
               count_ff <= count_ff - 1'b1;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign quotient    = quo_ff[31:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

/* hdl/display_surface_register_block_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Register block for a display surface window and a command ring window.
// Each item on the req channel is one register access: tuser carries the
// window and the access kind, tdata the offset and the write data. Each
// access returns exactly one item on the rsp channel with the read data,
// the ring and surface interrupt pulses and the current geometry.
// The result item of an ordinary access is registered and appears in the cycle
// after acceptance. A write to surface-0 base, surface-0 pages or the stride
// with a complete surface and a nonzero stride starts the serial divider,
// which retires one quotient bit per cycle; that result item follows once the
// divider is done, and req_tready stays low meanwhile.
// The block takes one item at a time: req_tready is high only while no
// division runs and the result register is empty or being drained.
// When the receiver stalls, the result item is held in the output
// register and no further item is accepted until it is taken.
// A synchronous reset returns all configuration registers to their reset values
// (stride 4096, width and height 1024, all else zero) and empties the output.

module display_surface_register_block_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // offset [15:0], wdata [79:16]
   input  wire  [dsrb_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // window [0], cmd [1]
   input  wire  [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // rdata [63:0], ring_irq [64], surface_irq [65], surface_width [97:66],
   // surface_height [129:98], surface_ready [130], zero [135:131]
   output logic [dsrb_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic        req_window;
   logic        req_cmd;
   logic [15:0] req_offset;
   logic [63:0] req_wdata;
   logic        accept;

   assign req_window = req_tuser[0];
   assign req_cmd    = req_tuser[1];
   assign req_offset = req_tdata[15:0];
   assign req_wdata  = req_tdata[79:16];
   assign accept     = req_tvalid && req_tready;

   logic [31:0] status_ff,  status_in;
   logic [63:0] base0_ff,   base0_in;
   logic [63:0] base1_ff,   base1_in;
   logic [31:0] pages0_ff,  pages0_in;
   logic [31:0] pages1_ff,  pages1_in;
   logic [31:0] stride_ff,  stride_in;
   logic [31:0] width_ff,   width_in;
   logic [31:0] height_ff,  height_in;
   logic        ready_ff,   ready_in;
   logic [31:0] control_ff, control_in;
   logic [31:0] command_ff, command_in;
   logic [31:0] rlen0_ff,   rlen0_in;
   logic [31:0] rlen1_ff,   rlen1_in;
   logic [31:0] rpage0_ff,  rpage0_in;
   logic [31:0] rpage1_ff,  rpage1_in;
   logic [31:0] head_ff,    head_in;
   logic [31:0] tail_ff,    tail_in;

   logic        trigger;
   logic        ring_irq;
   logic        surf_irq;
   logic        div_start;
   logic [63:0] rdata;

   logic                      rsp_valid_ff;
   logic [63:0]               rsp_rdata_ff;
   logic                      rsp_rirq_ff;
   logic                      rsp_sirq_ff;
   logic [31:0]               rsp_width_ff;
   logic [31:0]               rsp_height_ff;
   logic                      rsp_ready_ff;

   logic [31:0]               quotient;
   dsrb_pkg::div_status_type  div_status;

   dsrb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({pages0_in, dsrb_pkg::PAGE_SHIFT'(0)}),
      .divisor  (stride_in),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      rdata = '0;
      if (req_window == dsrb_pkg::WIN_SURFACE) begin
         case (req_offset)
            dsrb_pkg::SURF_STATUS: rdata = {32'd0, status_ff};
            dsrb_pkg::SURF_BASE0:  rdata = base0_ff;
            dsrb_pkg::SURF_PAGES0: rdata = {32'd0, pages0_ff};
            dsrb_pkg::SURF_BASE1:  rdata = base1_ff;
            dsrb_pkg::SURF_PAGES1: rdata = {32'd0, pages1_ff};
            dsrb_pkg::SURF_STRIDE: rdata = {32'd0, stride_ff};
            default:               rdata = '0;
         endcase
      end else begin
         case (req_offset)
            dsrb_pkg::CQ_CONTROL: rdata = {32'd0, control_ff};
            dsrb_pkg::CQ_LEN0:    rdata = {32'd0, rlen0_ff};
            dsrb_pkg::CQ_HEAD:    rdata = {32'd0, head_ff};
            dsrb_pkg::CQ_TAIL:    rdata = {32'd0, tail_ff};
            dsrb_pkg::CQ_LEN1:    rdata = {32'd0, rlen1_ff};
            dsrb_pkg::CQ_PAGE0:   rdata = {32'd0, rpage0_ff};
            dsrb_pkg::CQ_PAGE1:   rdata = {32'd0, rpage1_ff};
            dsrb_pkg::CQ_COMMAND: rdata = {32'd0, command_ff};
            default:              rdata = '0;
         endcase
      end
      if (req_cmd == dsrb_pkg::CMD_WRITE) begin
         rdata = '0;
      end
   end

   always_comb begin
      status_in  = status_ff;
      base0_in   = base0_ff;
      base1_in   = base1_ff;
      pages0_in  = pages0_ff;
      pages1_in  = pages1_ff;
      stride_in  = stride_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      ready_in   = ready_ff;
      control_in = control_ff;
      command_in = command_ff;
      rlen0_in   = rlen0_ff;
      rlen1_in   = rlen1_ff;
      rpage0_in  = rpage0_ff;
      rpage1_in  = rpage1_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      trigger    = 1'b0;
      ring_irq   = 1'b0;
      surf_irq   = 1'b0;
      div_start  = 1'b0;

      if (accept && req_cmd == dsrb_pkg::CMD_WRITE) begin
         if (req_window == dsrb_pkg::WIN_SURFACE) begin
            case (req_offset)
               dsrb_pkg::SURF_STATUS: status_in = req_wdata[31:0];
               dsrb_pkg::SURF_BASE0: begin
                  base0_in = req_wdata;
                  trigger  = 1'b1;
               end
               dsrb_pkg::SURF_PAGES0: begin
                  pages0_in = req_wdata[31:0];
                  trigger   = 1'b1;
               end
               dsrb_pkg::SURF_BASE1:  base1_in  = req_wdata;
               dsrb_pkg::SURF_PAGES1: pages1_in = req_wdata[31:0];
               dsrb_pkg::SURF_STRIDE: begin
                  stride_in = req_wdata[31:0];
                  trigger   = 1'b1;
               end
               default: trigger = 1'b0;
            endcase
         end else begin
            case (req_offset)
               dsrb_pkg::CQ_CONTROL: control_in = req_wdata[31:0];
               dsrb_pkg::CQ_LEN0:    rlen0_in   = req_wdata[31:0];
               dsrb_pkg::CQ_HEAD: begin
                  head_in  = req_wdata[31:0];
                  tail_in  = req_wdata[31:0];
                  ring_irq = 1'b1;
               end
               dsrb_pkg::CQ_TAIL:  tail_in   = req_wdata[31:0];
               dsrb_pkg::CQ_LEN1:  rlen1_in  = req_wdata[31:0];
               dsrb_pkg::CQ_PAGE0: rpage0_in = req_wdata[31:0];
               dsrb_pkg::CQ_PAGE1: rpage1_in = req_wdata[31:0];
               dsrb_pkg::CQ_COMMAND: begin
                  command_in = req_wdata[31:0];
                  ring_irq   = 1'b1;
               end
               default: ring_irq = 1'b0;
            endcase
         end
      end

      if (trigger && base0_in != 64'd0 && pages0_in != 32'd0) begin
         ready_in = 1'b1;
         surf_irq = 1'b1;
         if (stride_in == 32'd0) begin
            if (pages0_in >= dsrb_pkg::FULL_HD_PAGES) begin
               width_in  = dsrb_pkg::HD_WIDTH;
               height_in = dsrb_pkg::HD_HEIGHT;
               stride_in = dsrb_pkg::HD_STRIDE;
            end else begin
               width_in  = dsrb_pkg::DEF_DIM;
               stride_in = dsrb_pkg::DEF_STRIDE;
               height_in = pages0_in;
            end
         end else begin
            width_in  = (stride_in[31:2] == 30'd0) ? dsrb_pkg::DEF_DIM
                                                   : {2'b00, stride_in[31:2]};
            div_start = 1'b1;
         end
      end

      if (state_ff == ST_DIV && div_status.done) begin
         height_in = (quotient == 32'd0) ? dsrb_pkg::DEF_DIM : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         base0_ff   <= '0;
         base1_ff   <= '0;
         pages0_ff  <= '0;
         pages1_ff  <= '0;
         stride_ff  <= dsrb_pkg::DEF_STRIDE;
         width_ff   <= dsrb_pkg::DEF_DIM;
         height_ff  <= dsrb_pkg::DEF_DIM;
         ready_ff   <= 1'b0;
         control_ff <= '0;
         command_ff <= '0;
         rlen0_ff   <= '0;
         rlen1_ff   <= '0;
         rpage0_ff  <= '0;
         rpage1_ff  <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         status_ff  <= status_in;
         base0_ff   <= base0_in;
         base1_ff   <= base1_in;
         pages0_ff  <= pages0_in;
         pages1_ff  <= pages1_in;
         stride_ff  <= stride_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         ready_ff   <= ready_in;
         control_ff <= control_in;
         command_ff <= command_in;
         rlen0_ff   <= rlen0_in;
         rlen1_ff   <= rlen1_in;
         rpage0_ff  <= rpage0_in;
         rpage1_ff  <= rpage1_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && div_start) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_DIV;
               end else if (accept) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_rdata_ff  <= rdata;
                  rsp_rirq_ff   <= ring_irq;
                  rsp_sirq_ff   <= surf_irq;
                  rsp_width_ff  <= width_in;
                  rsp_height_ff <= height_in;
                  rsp_ready_ff  <= ready_in;
               end else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_DIV: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (div_status.done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_rdata_ff  <= '0;
                  rsp_rirq_ff   <= 1'b0;
                  rsp_sirq_ff   <= 1'b1;
                  rsp_width_ff  <= width_ff;
                  rsp_height_ff <= height_ff;
                  rsp_ready_ff  <= ready_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ready_ff, rsp_height_ff, rsp_width_ff,
                        rsp_sirq_ff, rsp_rirq_ff, rsp_rdata_ff};

`ifndef SYNTHESIS
   a_sirq_implies_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> rsp_tdata[130])
      else $error("surface interrupt without a configured surface");

   a_irq_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("ring and surface interrupts in one item");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_tready)
      else $error("request taken while the divider is busy");

   a_height_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[129:98] != 32'd0))
      else $error("zero height reported");
`endif

endmodule

`default_nettype wire
